[hw/rtl/lru_key_cache_unit_macros.svh]
// Assertion macros used by the LRU key cache RTL (the slot array).
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef LRU_KEY_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_CACHE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked at every clock edge while reset is low.
`define LRUKC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Checked at every clock edge, reset included.
`define LRUKC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define LRUKC_ASSERT(lbl, prop, msg)
`define LRUKC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[hw/rtl/lrukc_pkg.sv]
// Package of the LRU key cache: field widths and the lookup result type.
// Depends on nothing; used by the interfaces, the slot array and the top level.
`default_nettype none

package lrukc_pkg;

   localparam int KEY_FIELD_WIDTH  = 64;
   localparam int SLOT_FIELD_WIDTH = 4;

   typedef struct packed {
      logic                        hit;
      logic [SLOT_FIELD_WIDTH-1:0] slot;
      logic                        replaced;
   } lookup_result_type;

endpackage

`default_nettype wire

[hw/rtl/lrukc_req_if.sv]
// Request channel of the LRU key cache: valid/ready handshake with one key.
// Depends on lrukc_pkg for the key field width.
`default_nettype none

interface lrukc_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [lrukc_pkg::KEY_FIELD_WIDTH-1:0] lookup_key;

   modport source (output valid, output lookup_key, input ready);
   modport sink   (input valid, input lookup_key, output ready);
endinterface

`default_nettype wire

[hw/rtl/lrukc_rsp_if.sv]
// Response channel of the LRU key cache: valid/ready handshake with the lookup result.
// Depends on lrukc_pkg for the slot field width.
`default_nettype none

interface lrukc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  hit;
   logic [lrukc_pkg::SLOT_FIELD_WIDTH-1:0] slot;
   logic                                  replaced;

   modport source (output valid, output hit, output slot, output replaced, input ready);
   modport sink   (input valid, input hit, input slot, input replaced, output ready);
endinterface

`default_nettype wire

[hw/rtl/lrukc_slot_array.sv]
// Slot storage of the LRU key cache: keys, valid marks, recency ranks and the
// single-pass lookup and update logic. Depends on lrukc_pkg and the macros header.
`default_nettype none
`include "lru_key_cache_unit_macros.svh"

module lrukc_slot_array #(
   parameter int ENTRIES   = 16,
   parameter int KEY_WIDTH = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic [KEY_WIDTH-1:0]          key,
   output      lrukc_pkg::lookup_result_type  result
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int EXT_W = (IDX_W > lrukc_pkg::SLOT_FIELD_WIDTH) ? IDX_W
                                                                : lrukc_pkg::SLOT_FIELD_WIDTH;
   localparam logic [IDX_W-1:0] MRU_RANK = IDX_W'(ENTRIES - 1);

   logic [KEY_WIDTH-1:0] key_ff   [ENTRIES];
   logic [ENTRIES-1:0]   valid_ff;
   logic [IDX_W-1:0]     rank_ff  [ENTRIES];

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] lru;
   logic [ENTRIES-1:0] sel;
   logic               hit;
   logic [IDX_W-1:0]   idx;
   logic [IDX_W-1:0]   old_rank;
   logic [EXT_W-1:0]   idx_ext;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == key);
         lru[i]   = (rank_ff[i] == '0);
      end
      hit = |match;
      sel = hit ? match : lru;
      // Valid keys are distinct and the ranks are a permutation, so sel is one-hot
      // and the index and old rank can be gathered by OR.
      idx      = '0;
      old_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel[i]) begin
            idx      = idx | IDX_W'(i);
            old_rank = old_rank | rank_ff[i];
         end
      end
      idx_ext         = EXT_W'(idx);
      result.hit      = hit;
      result.slot     = idx_ext[lrukc_pkg::SLOT_FIELD_WIDTH-1:0];
      result.replaced = !hit && |(lru & valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= IDX_W'(ENTRIES - 1 - i);
         end
      end else if (fire) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (sel[i]) begin
               rank_ff[i] <= MRU_RANK;
            end else if (rank_ff[i] > old_rank) begin
               rank_ff[i] <= rank_ff[i] - 1'b1;
            end
            if (sel[i] && !hit) begin
               valid_ff[i] <= 1'b1;
            end
         end
      end
   end

   // Key storage has no reset; a key is only ever read behind its valid mark.
   always_ff @(posedge clock) begin
      if (fire && !hit) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (sel[i]) begin
               key_ff[i] <= key;
            end
         end
      end
   end

   `LRUKC_ASSERT(a_lru_onehot, $onehot(lru), "ranks lost their permutation")
   `LRUKC_ASSERT(a_match_onehot0, $onehot0(match), "a key is stored in two valid slots")
   `LRUKC_ASSERT(a_touched_mru, fire |=> (rank_ff[$past(idx)] == MRU_RANK),
                 "touched slot did not become most recent")
   `LRUKC_ASSERT(a_fill_valid, (fire && !hit) |=> valid_ff[$past(idx)],
                 "filled slot is not valid")

endmodule

`default_nettype wire

[hw/rtl/lru_key_cache_unit.sv]
// Top level of the LRU key cache: input register, slot array, result register.
// Depends on lrukc_pkg, lrukc_req_if, lrukc_rsp_if and lrukc_slot_array.
`default_nettype none

// A fully associative cache of ENTRIES keys with exact least-recently-used
// replacement. Every request carries one key and yields exactly one response,
// in order. On a hit the response reports hit=1 and the slot holding the key,
// and that slot becomes most recent. On a miss the least recent slot is
// refilled with the key and reported with hit=0; replaced is 1 when the slot
// held a valid key before. After reset no slot is valid and slots are taken
// from ENTRIES-1 downward. Only the low KEY_WIDTH bits of the key are used, and
// the slot number is reported in four bits (masked when ENTRIES exceeds 16).
// The block accepts one request per clock cycle, sustained, while responses
// are taken. A request is registered in the input register on acceptance;
// the parallel key compare and rank update then run against all slots and
// the result is registered in the result register, from which the response
// is presented until it is taken. The state update happens in the same cycle
// as the compare, which lets the next request see it immediately.
// Response backpressure stalls the pipeline through a combinational ready path.

module lru_key_cache_unit #(
   parameter int ENTRIES   = 16,
   parameter int KEY_WIDTH = 64
) (
   input wire logic    clock,
   input wire logic    reset,
   lrukc_req_if.sink   req_bus,
   lrukc_rsp_if.source rsp_bus
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [KEY_WIDTH-1:0] key_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   logic                 advance;
   logic                 req_fire;

   lrukc_pkg::lookup_result_type result;
   lrukc_pkg::lookup_result_type result_ff;

   // The held request moves on when the result register is empty or is being drained.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_fire     = req_bus.valid && req_bus.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         key_ff <= req_bus.lookup_key[KEY_WIDTH-1:0];
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   lrukc_slot_array #(
      .ENTRIES   (ENTRIES),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_slots (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .key    (key_ff),
      .result (result)
   );

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.hit      = result_ff.hit;
   assign rsp_bus.slot     = result_ff.slot;
   assign rsp_bus.replaced = result_ff.replaced;

endmodule

`default_nettype wire

[bench/tb_lru_key_cache_unit.sv]
// Self-checking testbench for lru_key_cache_unit: random lookup traffic
// checked against a cycle-free LRU predictor.
// Depends on lrukc_pkg, lrukc_req_if, lrukc_rsp_if and the lru_key_cache_unit RTL.
`default_nettype none

module tb_lru_key_cache_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_FIELD_WIDTH  = lrukc_pkg::KEY_FIELD_WIDTH;
   localparam int SLOT_FIELD_WIDTH = lrukc_pkg::SLOT_FIELD_WIDTH;
   typedef lrukc_pkg::lookup_result_type lookup_result_type;

   // The block is built with its default geometry: 16 slots of 64-bit keys.
   localparam int CACHE_LINES = 16;
   localparam int KEY_BITS    = KEY_FIELD_WIDTH;
   localparam logic [KEY_FIELD_WIDTH-1:0] KEY_MASK =
      {KEY_FIELD_WIDTH{1'b1}} >> (KEY_FIELD_WIDTH - KEY_BITS);
   localparam int RANDOM_LOOKUPS = 1900;
   localparam int DRAIN_CYCLES   = 20;
   // Long receiver hold-offs start once this many requests have gone in.
   localparam int FIRST_HOLD_AT  = 400;
   localparam int SECOND_HOLD_AT = 1300;
   localparam int HOLD_CYCLES    = 150;
   localparam int REPORT_LIMIT   = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lrukc_req_if req_if ();
   lrukc_rsp_if rsp_if ();

   lru_key_cache_unit #(
      .ENTRIES   (CACHE_LINES),
      .KEY_WIDTH (KEY_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Every input of the block holds a known value before the first edge.
   initial begin
      req_if.valid      = 1'b0;
      req_if.lookup_key = '0;
      rsp_if.ready      = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the cache: stored keys, valid marks and the recency
   // ranks (0 is least recent, CACHE_LINES-1 is most recent).
   // ------------------------------------------------------------------
   logic [KEY_FIELD_WIDTH-1:0] line_key   [CACHE_LINES];
   logic                       line_valid [CACHE_LINES];
   int                         line_rank  [CACHE_LINES];

   logic [KEY_FIELD_WIDTH-1:0] pending_keys[$];
   lookup_result_type          expected_results[$];

   int requests_sent;
   int responses_seen;
   int hits_seen;
   int evictions_seen;
   int error_count;
   int reported_count;

   // After reset no slot is valid and slot CACHE_LINES-1 is the least
   // recent, so misses fill the slots from the top down.
   initial begin
      for (int i = 0; i < CACHE_LINES; i++) begin
         line_key[i]   = '0;
         line_valid[i] = 1'b0;
         line_rank[i]  = CACHE_LINES - 1 - i;
      end
   end

   // Looks up one key in the shadow cache, updates it the way the block
   // does, and returns the response the block must give for this request.
   function automatic lookup_result_type predict_lookup(
      input logic [KEY_FIELD_WIDTH-1:0] raw_key);
      lookup_result_type          res;
      logic [KEY_FIELD_WIDTH-1:0] key;
      int                         found;
      int                         old_rank;
      bit                         is_hit;
      bit                         have_lru;
      bit                         evicted;
      key      = raw_key & KEY_MASK;
      found    = 0;
      is_hit   = 1'b0;
      have_lru = 1'b0;
      evicted  = 1'b0;
      // Only valid slots take part in the compare, so a zero key never
      // matches an empty slot.
      for (int i = 0; i < CACHE_LINES; i++) begin
         if (!is_hit && line_valid[i] && line_key[i] == key) begin
            found  = i;
            is_hit = 1'b1;
         end
      end
      if (!is_hit) begin
         for (int i = 0; i < CACHE_LINES; i++) begin
            if (!have_lru && line_rank[i] == 0) begin
               found    = i;
               have_lru = 1'b1;
            end
         end
         evicted           = line_valid[found];
         line_key[found]   = key;
         line_valid[found] = 1'b1;
      end
      // Everything more recent than the touched slot moves down one rank.
      old_rank = line_rank[found];
      for (int i = 0; i < CACHE_LINES; i++) begin
         if (line_rank[i] > old_rank) line_rank[i] = line_rank[i] - 1;
      end
      line_rank[found] = CACHE_LINES - 1;
      res.hit      = is_hit;
      res.slot     = SLOT_FIELD_WIDTH'(found);
      res.replaced = evicted;
      return res;
   endfunction

   // Random 64-bit key; now and then a sparse one so that single bits and
   // short runs get exercised against the compare logic.
   function automatic logic [KEY_FIELD_WIDTH-1:0] random_key();
      logic [KEY_FIELD_WIDTH-1:0] k;
      k = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0) k = k & {$urandom, $urandom} & {$urandom, $urandom};
      return k;
   endfunction

   // ------------------------------------------------------------------
   // Request driver. It sends the pending keys in bursts of random length
   // separated by random gaps. A request stays on the bus until the block
   // takes it; the prediction is made at the edge where it is accepted.
   // ------------------------------------------------------------------
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin : request_driver
      logic                       next_valid;
      logic [KEY_FIELD_WIDTH-1:0] next_key;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         next_valid = req_if.valid;
         next_key   = req_if.lookup_key;
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(predict_lookup(req_if.lookup_key));
            requests_sent++;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_keys.size() > 0) begin
               next_valid = 1'b1;
               next_key   = pending_keys.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 48);
                  // Mostly back-to-back bursts, with the odd long pause.
                  case ($urandom_range(0, 7))
                     0, 1, 2, 3: gap_left = 0;
                     4, 5:       gap_left = $urandom_range(1, 3);
                     6:          gap_left = $urandom_range(4, 12);
                     default:    gap_left = $urandom_range(13, 30);
                  endcase
               end
            end
         end
         req_if.valid      <= next_valid;
         req_if.lookup_key <= next_key;
      end
   end

   // ------------------------------------------------------------------
   // Response receiver. The ready pattern changes every window: always
   // ready, coin flip, a rotating 8-bit pattern, or mostly ready. Twice in
   // the run it holds off for HOLD_CYCLES while requests keep coming, so
   // the pipeline fills and the block has to stall its request side.
   // ------------------------------------------------------------------
   int       window_left = 0;
   int       stall_mode  = 0;
   int       hold_left   = 0;
   int       holds_done  = 0;
   logic [7:0] stall_pattern = 8'hff;

   always @(posedge clock) begin : response_receiver
      logic next_ready;
      if (window_left == 0) begin
         window_left   = $urandom_range(16, 96);
         stall_mode    = $urandom_range(0, 3);
         stall_pattern = 8'($urandom) | 8'h01;
      end else begin
         window_left--;
      end
      if (hold_left == 0 &&
          ((holds_done == 0 && requests_sent >= FIRST_HOLD_AT) ||
           (holds_done == 1 && requests_sent >= SECOND_HOLD_AT))) begin
         hold_left = HOLD_CYCLES;
         holds_done++;
      end
      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else begin
         case (stall_mode)
            0:       next_ready = 1'b1;
            1:       next_ready = 1'($urandom_range(0, 1));
            2: begin
               next_ready    = stall_pattern[0];
               stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            end
            default: next_ready = ($urandom_range(0, 7) != 0);
         endcase
      end
      rsp_if.ready <= next_ready;
   end

   // ------------------------------------------------------------------
   // Response monitor. Every accepted response is checked against the
   // oldest prediction, field by field.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : response_monitor
      lookup_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         responses_seen++;
         if (expected_results.size() == 0) begin
            error_count++;
            if (reported_count < REPORT_LIMIT) begin
               reported_count++;
               $display("Unexpected response %0d: hit=%0b slot=%0d replaced=%0b",
                        responses_seen, rsp_if.hit, rsp_if.slot, rsp_if.replaced);
            end
         end else begin
            want = expected_results.pop_front();
            if (want.hit) hits_seen++;
            if (want.replaced) evictions_seen++;
            if (rsp_if.hit !== want.hit || rsp_if.slot !== want.slot ||
                rsp_if.replaced !== want.replaced) begin
               error_count++;
               if (reported_count < REPORT_LIMIT) begin
                  reported_count++;
                  $display("Mismatch on response %0d: expected hit=%0b slot=%0d replaced=%0b,",
                           responses_seen, want.hit, want.slot, want.replaced,
                           " got hit=%0b slot=%0d replaced=%0b",
                           rsp_if.hit, rsp_if.slot, rsp_if.replaced);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run.
   // ------------------------------------------------------------------
   initial begin : stimulus
      logic [KEY_FIELD_WIDTH-1:0] pool[$];
      logic [KEY_FIELD_WIDTH-1:0] old_pool[$];
      logic [KEY_FIELD_WIDTH-1:0] base;
      logic [KEY_FIELD_WIDTH-1:0] k;
      int                         pool_size;
      int                         phase_len;
      int                         pick;
      int                         random_items;

      // Directed part. A zero key first: it must miss although the empty
      // slots hold nothing, then hit once it is stored. The all-ones key,
      // single bits and alternating patterns fill the other slots, so the
      // next new key recycles the least recent slot and evicts a valid key.
      pending_keys.push_back('0);
      pending_keys.push_back('0);
      pending_keys.push_back('1);
      pending_keys.push_back(64'h0000_0000_0000_0001);
      pending_keys.push_back(64'h8000_0000_0000_0000);
      pending_keys.push_back(64'haaaa_aaaa_aaaa_aaaa);
      pending_keys.push_back(64'h5555_5555_5555_5555);
      for (int i = 0; i < 10; i++) pending_keys.push_back(64'h1 << (4 * i + 3));
      pending_keys.push_back(64'hdead_beef_0123_4567);
      // A hit on an older line, then the zero key again, which by now was
      // evicted and comes back on a miss that evicts the least recent key.
      pending_keys.push_back('1);
      pending_keys.push_back('0);
      pending_keys.push_back('0);
      pending_keys.push_back(64'hdead_beef_0123_4567);

      // Random part in phases. Each phase works on its own pool of keys,
      // from well inside the cache size to somewhat beyond it, so runs of
      // hits alternate with thrashing. Pool keys are sometimes one-bit
      // neighbors of a shared base key to stress the compare.
      random_items = 0;
      while (random_items < RANDOM_LOOKUPS) begin
         old_pool  = pool;
         pool.delete();
         pool_size = $urandom_range(4, 24);
         base      = random_key();
         for (int j = 0; j < pool_size; j++) begin
            if ($urandom_range(0, 3) == 0)
               pool.push_back(base ^ (64'h1 << $urandom_range(0, 63)));
            else pool.push_back(random_key());
         end
         phase_len = $urandom_range(40, 200);
         for (int j = 0; j < phase_len && random_items < RANDOM_LOOKUPS; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) k = pool[$urandom_range(0, pool.size() - 1)];
            else if (pick < 87 && old_pool.size() > 0)
               k = old_pool[$urandom_range(0, old_pool.size() - 1)];
            else if (pick < 90) k = '0;
            else if (pick < 93) k = '1;
            else k = random_key();
            pending_keys.push_back(k);
            random_items++;
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every response to be back,
      // then give the pipeline time to show any stray response.
      while (pending_keys.size() != 0 || req_if.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_results.size() != 0) begin
         error_count += expected_results.size();
         $display("%0d predicted responses never arrived", expected_results.size());
      end
      $display("Covered %0d lookups: %0d hits, %0d misses, %0d evictions of valid keys",
               requests_sent, hits_seen, requests_sent - hits_seen, evictions_seen);
      $display("Response mismatches or unexpected responses: %0d", error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Safety net: far beyond the slowest correct run, long holds included.
   initial begin : watchdog
      #2_000_000;
      $display("Timeout with %0d requests accepted and %0d responses seen",
               requests_sent, responses_seen);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
